### hdl/tml_pkg.sv
// Shared types, constants and control bundles of the truncated mean estimator.
package tml_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int SAMPLE_W    = 24;
  localparam int USED_W      = 4;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int SUM_W       = SAMPLE_W + IDX_W;
  localparam int DCNT_W      = $clog2(SUM_W);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [USED_W-1:0]   used_t;
  typedef logic [DCNT_W-1:0]   dcnt_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    sum_t    a;
    sum_t    b;
  } alu_req_t;

  typedef struct packed {
    sum_t res;
    logic borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic    we;
    idx_t    waddr;
    sample_t wdata;
    idx_t    raddr;
  } store_req_t;

  typedef struct packed {
    sample_t mean;
    used_t   used;
    logic    too_few;
    logic    overflow;
  } result_t;

endpackage

### hdl/tml_in_if.sv
// Sample channel: one dE/dx sample per request with a last-of-track flag.
interface tml_in_if;
  import tml_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

### hdl/tml_out_if.sv
// Result channel: one truncated mean per track.
interface tml_out_if;
  import tml_pkg::*;

  logic    valid;
  logic    ready;
  sample_t mean;
  used_t   used;
  logic    too_few;
  logic    overflow;

  modport source (output valid, output mean, output used, output too_few,
                  output overflow, input ready);
  modport sink   (input valid, input mean, input used, input too_few,
                  input overflow, output ready);
endinterface

### hdl/tml_alu.sv
// Shared add/subtract unit used for insertion compares, summing and division.
module tml_alu (
  input  tml_pkg::alu_req_t req,
  output tml_pkg::alu_rsp_t rsp
);
  import tml_pkg::*;

  logic [SUM_W:0] wide;

  always_comb begin
    unique case (req.op)
      ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
      default: wide = '0;
    endcase
    rsp.res    = wide[SUM_W-1:0];
    rsp.borrow = (req.op == ALU_SUB) && wide[SUM_W];
  end
endmodule

### hdl/tml_store.sv
// Sorted sample store: one write port, one read port.
module tml_store (
  input  logic                clk,
  input  tml_pkg::store_req_t req,
  output tml_pkg::sample_t    rdata
);
  import tml_pkg::*;

  sample_t mem_r [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  assign rdata = mem_r[req.raddr];
endmodule

### hdl/tml_ctrl.sv
// Sequencer: insertion walk, lower-half sum and restoring division.
module tml_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tml_pkg::sample_t    in_sample,
  input  logic                in_last,
  output tml_pkg::store_req_t store_req,
  input  tml_pkg::sample_t    store_rdata,
  output tml_pkg::alu_req_t   alu_req,
  input  tml_pkg::alu_rsp_t   alu_rsp,
  output logic                res_valid,
  input  logic                res_take,
  output tml_pkg::result_t    result
);
  import tml_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INSERT = 6'b000010,
    ST_HALF   = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  cnt_t    count_r, count_nxt;
  logic    ovf_r, ovf_nxt;
  logic    last_r, last_nxt;
  sample_t val_r, val_nxt;
  cnt_t    pos_r, pos_nxt;
  cnt_t    half_r, half_nxt;
  cnt_t    k_r, k_nxt;
  sum_t    acc_r, acc_nxt;
  cnt_t    rem_r, rem_nxt;
  dcnt_t   bit_r, bit_nxt;

  logic [CNT_W:0] trial;
  logic           shift;
  logic           fits;

  assign trial = {rem_r, acc_r[SUM_W-1]};
  assign shift = (pos_r != '0) && alu_rsp.borrow;
  assign fits  = !alu_rsp.borrow;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    half_nxt  = half_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;

    in_ready        = 1'b0;
    res_valid       = 1'b0;
    store_req.we    = 1'b0;
    store_req.waddr = pos_r[IDX_W-1:0];
    store_req.wdata = val_r;
    store_req.raddr = pos_r[IDX_W-1:0] - idx_t'(1);
    alu_req.op      = ALU_SUB;
    alu_req.a       = SUM_W'(val_r);
    alu_req.b       = SUM_W'(store_rdata);

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = in_last;
          if (count_r == cnt_t'(MAX_SAMPLES)) begin
            // drop the sample, the store is full
            ovf_nxt   = 1'b1;
            state_nxt = in_last ? ST_HALF : ST_IDLE;
          end else begin
            val_nxt   = in_sample;
            pos_nxt   = count_r;
            state_nxt = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        // compare against the entry below; shift it up or drop the sample in
        store_req.we    = 1'b1;
        store_req.wdata = shift ? store_rdata : val_r;
        if (shift) begin
          pos_nxt = pos_r - cnt_t'(1);
        end else begin
          count_nxt = count_r + cnt_t'(1);
          state_nxt = last_r ? ST_HALF : ST_IDLE;
        end
      end
      ST_HALF: begin
        half_nxt  = count_r >> 1;
        acc_nxt   = '0;
        k_nxt     = '0;
        state_nxt = (count_r >> 1) == '0 ? ST_DONE : ST_SUM;
      end
      ST_SUM: begin
        store_req.raddr = k_r[IDX_W-1:0];
        alu_req.op      = ALU_ADD;
        alu_req.a       = acc_r;
        alu_req.b       = SUM_W'(store_rdata);
        acc_nxt         = alu_rsp.res;
        k_nxt           = k_r + cnt_t'(1);
        if (k_r == half_r - cnt_t'(1)) begin
          rem_nxt   = '0;
          bit_nxt   = dcnt_t'(SUM_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, shifted into the accumulator
        alu_req.op = ALU_SUB;
        alu_req.a  = SUM_W'(trial);
        alu_req.b  = SUM_W'(half_r);
        rem_nxt    = fits ? alu_rsp.res[CNT_W-1:0] : trial[CNT_W-1:0];
        acc_nxt    = {acc_r[SUM_W-2:0], fits};
        bit_nxt    = bit_r - dcnt_t'(1);
        if (bit_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign result.mean     = acc_r[SAMPLE_W-1:0];
  assign result.used     = used_t'(half_r);
  assign result.too_few  = (half_r == '0);
  assign result.overflow = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    half_r <= half_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    bit_r  <= bit_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < half_r)
    else $error("division remainder not below divisor");

  a_sum_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> k_r < half_r)
    else $error("sum index beyond lower half");

  a_last_starts_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> state_r != ST_IDLE)
    else $error("last sample accepted without result sequence");
endmodule

### hdl/truncated_mean_lower_half_core.sv
// Truncated-mean dE/dx estimator: samples of a track enter one per request and are
// insertion-sorted into a 16-entry store; the last sample triggers the mean of the
// floor(n/2) smallest samples. Insertion walks the store one entry per cycle through
// the shared add/subtract unit, shifting each larger stored sample up one entry before
// the new sample is written; a dropped sample is not stored. After the last sample the
// same unit sums floor(n/2) entries, one per cycle, and runs a 28-step restoring
// division. The input is not ready while a sample or result is in work; one finished
// result is held in an output register so that the next track can start while it
// waits. Tracks of fewer than two samples give mean 0 with too_few set; samples past
// 16 are dropped and flagged with overflow.
module truncated_mean_lower_half_core (
  input  logic  clk,
  input  logic  rst_n,
  tml_in_if.sink     in_ch,
  tml_out_if.source  out_ch
);
  import tml_pkg::*;

  store_req_t store_req;
  sample_t    store_rdata;
  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  logic       res_valid;
  logic       res_take;
  result_t    result;

  logic    out_valid_r;
  result_t out_r;

  tml_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_sample   (in_ch.sample),
    .in_last     (in_ch.last),
    .store_req   (store_req),
    .store_rdata (store_rdata),
    .alu_req     (alu_req),
    .alu_rsp     (alu_rsp),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .result      (result)
  );

  tml_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  tml_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // load the output register when it is empty or being drained
  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= result;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.mean     = out_r.mean;
  assign out_ch.used     = out_r.used;
  assign out_ch.too_few  = out_r.too_few;
  assign out_ch.overflow = out_r.overflow;
endmodule
